[rtl/core/lkvc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the lru key-value cache
package lkvc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W       = 5;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	typedef struct packed {
		logic              func;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic              hit;
		logic signed [VAL_W-1:0] read_value;
	} out_item_t;

	typedef logic [MAX_ENTRIES-1:0][IDX_W-1:0] rank_vec_t;

	// request to the recency update unit
	typedef struct packed {
		logic             promote;
		logic             insert;
		logic [IDX_W-1:0] target;
		logic [IDX_W-1:0] tgt_rank;
	} rank_ctrl_t;

endpackage

[rtl/core/lru_key_value_cache.sv]
`timescale 1ns / 1ps
// top level of the fully associative lru key-value cache
// One item (get or put) is handled at a time. After acceptance a single key
// comparator walks the entries one per cycle. An item is taken, the walk
// visits every entry, and then the store and recency ranks are updated
// and the item's result is loaded into the result
// register. The result register lets the next item be taken while a result
// still waits; the update cycle holds if the previous result has not been
// taken. A get hit returns the value and hit=1, a get miss returns -1 with
// hit=0, a put returns 0 with hit telling whether the key was present. A put
// miss fills the lowest free entry until the capacity register is reached,
// then replaces the least recent entry. Capacity 0 acts as 1 and values above
// the entry count act as the entry count; lowering it flushes nothing. The
// store is empty after reset, with no clearing pass.
module lru_key_value_cache (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lkvc_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lkvc_pkg::out_item_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	localparam logic [lkvc_pkg::VAL_W-1:0] MISS_VALUE = '1;
	localparam logic [lkvc_pkg::IDX_W-1:0] LAST_IDX   =
		lkvc_pkg::IDX_W'(lkvc_pkg::MAX_ENTRIES - 1);

	// entry storage
	logic [lkvc_pkg::KEY_W-1:0]       key_q [lkvc_pkg::MAX_ENTRIES];
	logic [lkvc_pkg::VAL_W-1:0]       val_q [lkvc_pkg::MAX_ENTRIES];
	lkvc_pkg::rank_vec_t              rank_q;
	logic [lkvc_pkg::MAX_ENTRIES-1:0] valid_q;
	logic [lkvc_pkg::CNT_W-1:0]       fill_q;
	logic [lkvc_pkg::CAP_W-1:0]       cap_q;

	// sequencer and walk results
	logic [1:0]                 state_q;
	lkvc_pkg::in_item_t         req_q;
	logic [lkvc_pkg::IDX_W-1:0] idx_q;
	logic                       match_q;
	logic [lkvc_pkg::IDX_W-1:0] match_idx_q;
	logic [lkvc_pkg::IDX_W-1:0] match_rank_q;
	logic [lkvc_pkg::VAL_W-1:0] match_val_q;
	logic                       vic_found_q;
	logic [lkvc_pkg::IDX_W-1:0] vic_idx_q;
	logic [lkvc_pkg::IDX_W-1:0] vic_rank_q;
	logic                       free_found_q;
	logic [lkvc_pkg::IDX_W-1:0] free_idx_q;

	logic                       out_valid_q;
	lkvc_pkg::out_item_t        out_q;

	logic                       ent_valid;
	logic [lkvc_pkg::IDX_W-1:0] ent_rank;
	logic                       key_eq;
	logic                       upd_go;
	logic [lkvc_pkg::CNT_W-1:0] eff_cap;
	logic                       full;
	lkvc_pkg::rank_ctrl_t       rctrl;
	lkvc_pkg::rank_vec_t        rank_nxt;
	logic                       wr_en;
	logic                       wr_key;
	lkvc_pkg::out_item_t        res;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// shared comparator on the walked entry
	assign ent_valid = valid_q[idx_q];
	assign ent_rank  = rank_q[idx_q];
	assign key_eq    = ent_valid && (key_q[idx_q] == req_q.key);

	// update waits for the result register to be free
	assign upd_go = (state_q == ST_UPD) && (!out_valid_q || out_ready);

	// capacity clamped to 1 .. MAX_ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lkvc_pkg::CNT_W'(1);
		end else if (int'(cap_q) > lkvc_pkg::MAX_ENTRIES) begin
			eff_cap = lkvc_pkg::CNT_W'(lkvc_pkg::MAX_ENTRIES);
		end else begin
			eff_cap = lkvc_pkg::CNT_W'(cap_q);
		end
	end
	assign full = (fill_q >= eff_cap);

	// decide the action for the update cycle
	always_comb begin
		rctrl          = '0;
		wr_en          = 1'b0;
		wr_key         = 1'b0;
		res.hit        = match_q;
		res.read_value = '0;
		if (req_q.func == lkvc_pkg::FUNC_GET) begin
			if (match_q) begin
				rctrl.promote  = 1'b1;
				rctrl.target   = match_idx_q;
				rctrl.tgt_rank = match_rank_q;
				res.read_value = match_val_q;
			end else begin
				res.read_value = MISS_VALUE;
			end
		end else if (match_q) begin
			rctrl.promote  = 1'b1;
			rctrl.target   = match_idx_q;
			rctrl.tgt_rank = match_rank_q;
			wr_en          = 1'b1;
		end else if (full) begin
			// evict the least recent entry
			if (vic_found_q) begin
				rctrl.promote  = 1'b1;
				rctrl.target   = vic_idx_q;
				rctrl.tgt_rank = vic_rank_q;
				wr_en          = 1'b1;
				wr_key         = 1'b1;
			end
		end else if (free_found_q) begin
			rctrl.insert = 1'b1;
			rctrl.target = free_idx_q;
			wr_en        = 1'b1;
			wr_key       = 1'b1;
		end
	end

	lkvc_rank_unit u_rank (
		.rank     (rank_q),
		.valid    (valid_q),
		.ctrl     (rctrl),
		.rank_nxt (rank_nxt)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			fill_q      <= '0;
			cap_q       <= lkvc_pkg::CAP_W'(16);
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			// result register: loaded by the update, emptied when taken
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_UPD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_UPD: begin
					if (upd_go) begin
						if (rctrl.insert) begin
							valid_q[free_idx_q] <= 1'b1;
							fill_q              <= fill_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk bookkeeping and payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q        <= in_data;
				match_q      <= 1'b0;
				vic_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end
			ST_SCAN: begin
				if (key_eq) begin
					match_q      <= 1'b1;
					match_idx_q  <= idx_q;
					match_rank_q <= ent_rank;
					match_val_q  <= val_q[idx_q];
				end
				if (ent_valid && (!vic_found_q || ent_rank > vic_rank_q)) begin
					vic_found_q <= 1'b1;
					vic_idx_q   <= idx_q;
					vic_rank_q  <= ent_rank;
				end
				if (!ent_valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_q;
				end
			end
			ST_UPD: begin
				if (upd_go) begin
					out_q <= res;
					if (rctrl.promote || rctrl.insert) begin
						rank_q <= rank_nxt;
					end
					if (wr_en) begin
						val_q[rctrl.target] <= req_q.value;
					end
					if (wr_key) begin
						key_q[rctrl.target] <= req_q.key;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/lkvc_rank_unit.sv]
`timescale 1ns / 1ps
// recency rank update: promote an entry or insert a new most recent entry
module lkvc_rank_unit (
	input  lkvc_pkg::rank_vec_t                 rank,
	input  logic [lkvc_pkg::MAX_ENTRIES-1:0]    valid,
	input  lkvc_pkg::rank_ctrl_t                ctrl,
	output lkvc_pkg::rank_vec_t                 rank_nxt
);

	always_comb begin
		for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
			rank_nxt[i] = rank[i];
			if (ctrl.target == lkvc_pkg::IDX_W'(i)) begin
				rank_nxt[i] = '0;
			end else if (valid[i]) begin
				// insert ages every entry, promote only those newer than the target
				if (ctrl.insert || (ctrl.promote && rank[i] < ctrl.tgt_rank)) begin
					rank_nxt[i] = rank[i] + 1'b1;
				end
			end
		end
	end

endmodule

[verif/lru_key_value_cache_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the lru key-value cache
module lru_key_value_cache_tb;

	// one item is taken, walks over all entries and then updates the store
	localparam int LATENCY     = lkvc_pkg::MAX_ENTRIES + 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_ROWS    = 23;
	localparam int NUM_PHASES  = 10;
	localparam int PHASE_ITEMS = 60;
	localparam int MAX_REPORTS = 40;

	localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// directed stimulus row, capacity rides in value[4:0] for cfg rows
	typedef struct packed {
		row_kind_t   kind;
		logic        func;
		logic [31:0] key;
		logic [31:0] value;
		logic        typed;
		logic        exp_hit;
		logic [31:0] exp_value;
	} stim_row_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	lkvc_pkg::in_item_t         in_data   = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	lkvc_pkg::out_item_t        out_data;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [lkvc_pkg::CAP_W-1:0] cfg_data  = 5'd16;

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the cache contents and the capacity register
	logic [lkvc_pkg::KEY_W-1:0] shadow_key   [lkvc_pkg::MAX_ENTRIES];
	logic [lkvc_pkg::VAL_W-1:0] shadow_value [lkvc_pkg::MAX_ENTRIES];
	logic                       shadow_valid [lkvc_pkg::MAX_ENTRIES];
	int                         shadow_rank  [lkvc_pkg::MAX_ENTRIES];
	int                         shadow_fill;
	logic [lkvc_pkg::CAP_W-1:0] shadow_cap;

	lkvc_pkg::out_item_t pending_results [$];
	int        error_count   = 0;
	int        results_seen  = 0;
	int        cycle_count   = 0;
	bit        no_gaps       = 1'b0;

	// directed part: extremes of key and value, overwrite, get of an empty
	// store, value ignored on get, capacity lowered below the fill count,
	// capacity zero acting as one, capacity above the entry count
	stim_row_t directed_rows [0:NUM_ROWS-1] = '{
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, 32'd0,     32'd0,         1'b1, 1'b0, WORD_ONES},
		'{ROW_ITEM, lkvc_pkg::FUNC_PUT, WORD_MIN,  WORD_MAX,      1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, WORD_MIN,  32'd0,         1'b1, 1'b1, WORD_MAX},
		'{ROW_ITEM, lkvc_pkg::FUNC_PUT, WORD_MAX,  WORD_MIN,      1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, WORD_MAX,  32'd0,         1'b1, 1'b1, WORD_MIN},
		'{ROW_ITEM, lkvc_pkg::FUNC_PUT, WORD_MIN,  WORD_ONES,     1'b1, 1'b1, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, WORD_MIN,  32'd0,         1'b1, 1'b1, WORD_ONES},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, WORD_ONES, 32'd0,         1'b1, 1'b0, WORD_ONES},
		'{ROW_ITEM, lkvc_pkg::FUNC_PUT, WORD_ONES, 32'd0,         1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, WORD_ONES, 32'd0,         1'b1, 1'b1, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, 32'd0,     WORD_ONES,     1'b1, 1'b0, WORD_ONES},
		'{ROW_CFG,  lkvc_pkg::FUNC_GET, 32'd0,     32'd2,         1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_PUT, 32'd5,     32'h5555_5555, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, WORD_MAX,  32'd0,         1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, 32'd5,     32'd0,         1'b0, 1'b0, 32'd0},
		'{ROW_CFG,  lkvc_pkg::FUNC_GET, 32'd0,     32'd0,         1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_PUT, 32'd6,     32'hAAAA_AAAA, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, 32'd6,     32'd0,         1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_PUT, 32'd7,     32'd7,         1'b0, 1'b0, 32'd0},
		'{ROW_CFG,  lkvc_pkg::FUNC_GET, 32'd0,     32'd17,        1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_PUT, 32'd8,     32'd8,         1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, lkvc_pkg::FUNC_GET, 32'd7,     32'd0,         1'b0, 1'b0, 32'd0},
		'{ROW_CFG,  lkvc_pkg::FUNC_GET, 32'd0,     32'd16,        1'b0, 1'b0, 32'd0}
	};

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// capacity as the cache sees it: zero acts as one, clipped at the entry count
	function automatic int effective_capacity();
		if (shadow_cap == '0) return 1;
		if (int'(shadow_cap) > lkvc_pkg::MAX_ENTRIES) return lkvc_pkg::MAX_ENTRIES;
		return int'(shadow_cap);
	endfunction

	// move entry to rank 0, entries that were more recent age by one
	function automatic void make_most_recent(int e);
		int r;
		r = shadow_rank[e];
		for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
			if (shadow_valid[i] && i != e && shadow_rank[i] < r) shadow_rank[i]++;
		end
		shadow_rank[e] = 0;
	endfunction

	// apply one get or put to the shadow cache and return the result it gives
	function automatic lkvc_pkg::out_item_t cache_access(lkvc_pkg::in_item_t it);
		lkvc_pkg::out_item_t res;
		int        idx;
		int        victim;
		int        slot;
		idx    = -1;
		victim = -1;
		slot   = -1;
		res    = '0;
		for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
			if (idx < 0 && shadow_valid[i] && shadow_key[i] == it.key) idx = i;
		end
		if (it.func == lkvc_pkg::FUNC_GET) begin
			if (idx >= 0) begin
				res.hit        = 1'b1;
				res.read_value = shadow_value[idx];
				make_most_recent(idx);
			end else begin
				res.read_value = WORD_ONES;
			end
			return res;
		end
		if (idx >= 0) begin
			res.hit = 1'b1;
			make_most_recent(idx);
			shadow_value[idx] = it.value;
		end else if (shadow_fill >= effective_capacity()) begin
			// full: the highest rank is the least recent entry
			for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
				if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
					victim = i;
			end
			if (victim >= 0) begin
				make_most_recent(victim);
				shadow_key[victim]   = it.key;
				shadow_value[victim] = it.value;
			end
		end else begin
			// lowest free entry, every valid entry ages
			for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
				if (slot < 0 && !shadow_valid[i]) slot = i;
			end
			if (slot >= 0) begin
				for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
					if (shadow_valid[i]) shadow_rank[i]++;
				end
				shadow_valid[slot] = 1'b1;
				shadow_rank[slot]  = 0;
				shadow_key[slot]   = it.key;
				shadow_value[slot] = it.value;
				shadow_fill++;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_REPORTS) $display("mismatch: %s", msg);
		error_count++;
	endtask

	// offer one item after a random gap, predict it once accepted
	task automatic send_item(input lkvc_pkg::in_item_t it, input logic typed,
		input lkvc_pkg::out_item_t typed_res);
		int                  gap;
		lkvc_pkg::out_item_t predicted;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		predicted = cache_access(it);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// stop offering and wait until every outstanding result has been taken
	task automatic drain_cache();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// capacity is only written with the cache idle
	task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
		drain_cache();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		shadow_cap  = cap;
	endtask

	// result side: random stall per item, then hold ready until one is taken
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin
		lkvc_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = pending_results.pop_front();
				if (out_data.hit !== want.hit)
					report_mismatch($sformatf("result %0d hit got %0b want %0b",
						results_seen, out_data.hit, want.hit));
				if (out_data.read_value !== want.read_value)
					report_mismatch($sformatf("result %0d read_value got %h want %h",
						results_seen, out_data.read_value, want.read_value));
			end
			results_seen++;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		lkvc_pkg::in_item_t  it;
		lkvc_pkg::out_item_t typed_res;
		logic [31:0] key_pool [32];
		int          pool_n;
		int          phase_cap [NUM_PHASES];
		int          pick;

		phase_cap = '{16, 1, 31, 0, 17, 4, -1, 2, -1, 8};
		for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
			shadow_key[i]   = '0;
			shadow_value[i] = '0;
			shadow_valid[i] = 1'b0;
			shadow_rank[i]  = 0;
		end
		shadow_fill = 0;
		shadow_cap  = 5'd16;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				write_capacity(directed_rows[r].value[lkvc_pkg::CAP_W-1:0]);
			end else begin
				it.func              = directed_rows[r].func;
				it.key               = directed_rows[r].key;
				it.value             = directed_rows[r].value;
				typed_res.hit        = directed_rows[r].exp_hit;
				typed_res.read_value = directed_rows[r].exp_value;
				send_item(it, directed_rows[r].typed, typed_res);
			end
		end

		// random phases, each with its own capacity and a key pool sized to it
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (phase_cap[p] < 0) write_capacity(lkvc_pkg::CAP_W'($urandom_range(0, 31)));
			else write_capacity(lkvc_pkg::CAP_W'(phase_cap[p]));
			no_gaps = (p % 3 == 2);
			pool_n  = effective_capacity() + 3;
			for (int j = 0; j < pool_n; j++) begin
				pick = $urandom_range(0, 9);
				case (pick)
					0: key_pool[j] = WORD_MIN;
					1: key_pool[j] = WORD_MAX;
					2: key_pool[j] = 32'd0;
					3: key_pool[j] = WORD_ONES;
					default: key_pool[j] = $urandom;
				endcase
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold off once mid-phase until the cache has returned everything
				if (p == 4 && n == PHASE_ITEMS / 2) drain_cache();
				it.func  = $urandom_range(0, 1) ? lkvc_pkg::FUNC_PUT : lkvc_pkg::FUNC_GET;
				it.key   = ($urandom_range(0, 99) < 85) ?
					key_pool[$urandom_range(0, pool_n - 1)] : $urandom;
				it.value = $urandom;
				send_item(it, 1'b0, '0);
			end
		end

		drain_cache();
		repeat (2 * LATENCY) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
